### rtl/bhtq_pkg.sv
// ----------------------------------------------------------------------------
// bhtq_pkg: shared types and constants for the binary heap task queue
// Heap geometry, entry layout, opcodes, status codes and the command and
// status bundles between the queue controller and its datapath.
// ----------------------------------------------------------------------------
package bhtq_pkg;

   localparam int QUEUE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W       = ADDR_W + 2;
   localparam int ENTRY_W     = 9;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_PEEK = 2'd2;

   localparam logic [1:0] RSP_OK    = 2'd0;
   localparam logic [1:0] RSP_FULL  = 2'd1;
   localparam logic [1:0] RSP_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]  prio;
      logic [47:0] stamp;
   } key_type;

   typedef struct packed {
      key_type     key;
      logic [31:0] chunk_no;
      logic [3:0]  peer_slot;
      logic [2:0]  retries;
   } entry_type;

   // read address selection: parent of hole, both children of hole,
   // or root plus last entry
   typedef enum logic [1:0] {
      RD_UP,
      RD_DOWN,
      RD_ENDS
   } rd_mode_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_ITEM,
      WR_PARENT,
      WR_CHILD
   } wr_sel_type;

   typedef enum logic [2:0] {
      HOLE_KEEP,
      HOLE_COUNT,
      HOLE_ROOT,
      HOLE_PARENT,
      HOLE_BEST
   } hole_sel_type;

   typedef enum logic [1:0] {
      CNT_KEEP,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef struct packed {
      logic         load_req;
      logic         load_last;
      rd_mode_type  rd_mode;
      wr_sel_type   wr_sel;
      hole_sel_type hole_sel;
      cnt_op_type   cnt_op;
      logic         rsp_load;
      logic [1:0]   rsp_code;
      logic         rsp_root;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       empty;
      logic       full;
      logic       up_move;
      logic       dn_move;
   } dp_status_type;

endpackage

### rtl/bhtq_ctrl.sv
// ----------------------------------------------------------------------------
// bhtq_ctrl: queue sequencer
// Decodes the request and steps the datapath through push sift-up and pop
// sift-down, one heap level per cycle.
// ----------------------------------------------------------------------------
module bhtq_ctrl import bhtq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_TOP,
      S_UP,
      S_DOWN
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rd_mode  = RD_UP;
      cmd.wr_sel   = WR_NONE;
      cmd.hole_sel = HOLE_KEEP;
      cmd.cnt_op   = CNT_KEEP;
      cmd.rsp_code = RSP_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.op)
               OP_PUSH: begin
                  if (status.full) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_code = RSP_FULL;
                     state_in     = S_IDLE;
                  end else begin
                     cmd.hole_sel = HOLE_COUNT;
                     cmd.cnt_op   = CNT_INC;
                     cmd.rd_mode  = RD_UP;
                     state_in     = S_UP;
                  end
               end
               OP_POP, OP_PEEK: begin
                  if (status.empty) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_code = RSP_EMPTY;
                     state_in     = S_IDLE;
                  end else begin
                     cmd.rd_mode = RD_ENDS;
                     if (status.op == OP_POP) begin
                        cmd.cnt_op = CNT_DEC;
                     end
                     state_in = S_TOP;
                  end
               end
               default: begin
                  cmd.rsp_load = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_TOP: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_root = 1'b1;
            // last entry moves into the root hole and sinks
            if (status.op == OP_POP && !status.empty) begin
               cmd.load_last = 1'b1;
               cmd.hole_sel  = HOLE_ROOT;
               cmd.rd_mode   = RD_DOWN;
               state_in      = S_DOWN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_UP: begin
            if (status.up_move) begin
               cmd.wr_sel   = WR_PARENT;
               cmd.hole_sel = HOLE_PARENT;
               cmd.rd_mode  = RD_UP;
            end else begin
               cmd.wr_sel   = WR_ITEM;
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DOWN: begin
            if (status.dn_move) begin
               cmd.wr_sel   = WR_CHILD;
               cmd.hole_sel = HOLE_BEST;
               cmd.rd_mode  = RD_DOWN;
            end else begin
               cmd.wr_sel = WR_ITEM;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### rtl/bhtq_datapath.sv
// ----------------------------------------------------------------------------
// bhtq_datapath: heap storage and sift datapath
// Heap array with one write and two registered read ports, the moving entry,
// hole pointer, entry count, key comparators and the response registers.
// ----------------------------------------------------------------------------
module bhtq_datapath import bhtq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [1:0]    req_opcode,
   input  logic [2:0]    req_in_priority,
   input  logic [47:0]   req_in_created_at,
   input  logic [31:0]   req_in_chunk_index,
   input  logic [3:0]    req_in_peer_slot,
   input  logic [2:0]    req_in_retry_count,
   output logic          rsp_valid,
   output logic [1:0]    rsp_status,
   output logic [2:0]    rsp_out_priority,
   output logic [47:0]   rsp_out_created_at,
   output logic [31:0]   rsp_out_chunk_index,
   output logic [3:0]    rsp_out_peer_slot,
   output logic [2:0]    rsp_out_retry_count,
   output logic [8:0]    rsp_entry_count
);

   function automatic logic [IDX_W-1:0] left_of(input logic [ADDR_W-1:0] h);
      left_of = {1'b0, h, 1'b1};
   endfunction

   function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] h);
      parent_of = (h - ADDR_W'(1)) >> 1;
   endfunction

   entry_type heap_mem [QUEUE_DEPTH];

   logic [1:0]        op_ff;
   entry_type         item_ff;
   logic [ADDR_W-1:0] hole_ff;
   logic [ADDR_W-1:0] hole_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  count_m1;
   entry_type         rd_a_ff;
   entry_type         rd_b_ff;

   logic [IDX_W-1:0]  left_idx;
   logic [IDX_W-1:0]  right_idx;
   logic [IDX_W-1:0]  rd_left_idx;
   logic [IDX_W-1:0]  rd_right_idx;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;

   logic              l_ok;
   logic              r_ok;
   logic              lt_l;
   logic              r_lt_item;
   logic              r_lt_l;
   logic              pick_r;
   entry_type         child;
   logic              wr_en;
   entry_type         wr_data;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   entry_type         rsp_entry_ff;
   logic [ENTRY_W-1:0] rsp_count_ff;

   // child guards come from the current hole
   assign left_idx  = left_of(hole_ff);
   assign right_idx = left_idx + IDX_W'(1);
   assign l_ok      = left_idx  < IDX_W'(count_ff);
   assign r_ok      = right_idx < IDX_W'(count_ff);

   // port A holds the left child, port B the right child while sinking
   assign lt_l      = l_ok && (rd_a_ff.key < item_ff.key);
   assign r_lt_item = rd_b_ff.key < item_ff.key;
   assign r_lt_l    = rd_b_ff.key < rd_a_ff.key;
   assign pick_r    = r_ok && (lt_l ? r_lt_l : r_lt_item);
   assign child     = pick_r ? rd_b_ff : rd_a_ff;

   assign count_m1  = count_ff - CNT_W'(1);

   always_comb begin
      case (cmd.hole_sel)
         HOLE_COUNT:  hole_in = count_ff[ADDR_W-1:0];
         HOLE_ROOT:   hole_in = '0;
         HOLE_PARENT: hole_in = parent_of(hole_ff);
         HOLE_BEST:   hole_in = pick_r ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
         default:     hole_in = hole_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CNT_W'(1);
         CNT_DEC: count_in = count_m1;
         default: count_in = count_ff;
      endcase
   end

   // reads follow the next hole so one level completes per cycle
   assign rd_left_idx  = left_of(hole_in);
   assign rd_right_idx = rd_left_idx + IDX_W'(1);

   always_comb begin
      case (cmd.rd_mode)
         RD_DOWN: begin
            rd_addr_a = rd_left_idx[ADDR_W-1:0];
            rd_addr_b = rd_right_idx[ADDR_W-1:0];
         end
         RD_ENDS: begin
            rd_addr_a = '0;
            rd_addr_b = count_m1[ADDR_W-1:0];
         end
         default: begin
            rd_addr_a = parent_of(hole_in);
            rd_addr_b = parent_of(hole_in);
         end
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_ITEM: begin
            wr_en   = 1'b1;
            wr_data = item_ff;
         end
         WR_PARENT: begin
            wr_en   = 1'b1;
            wr_data = rd_a_ff;
         end
         WR_CHILD: begin
            wr_en   = 1'b1;
            wr_data = child;
         end
         default: begin
            wr_en   = 1'b0;
            wr_data = item_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[hole_ff] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff               <= req_opcode;
         item_ff.key.prio    <= req_in_priority;
         item_ff.key.stamp   <= req_in_created_at;
         item_ff.chunk_no    <= req_in_chunk_index;
         item_ff.peer_slot   <= req_in_peer_slot;
         item_ff.retries     <= req_in_retry_count;
      end else if (cmd.load_last) begin
         item_ff <= rd_b_ff;
      end
      hole_ff <= hole_in;
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_code;
         rsp_entry_ff  <= cmd.rsp_root ? rd_a_ff : '0;
         rsp_count_ff  <= ENTRY_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   assign status.op      = op_ff;
   assign status.empty   = (count_ff == '0);
   assign status.full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.up_move = (hole_ff != '0) && (item_ff.key < rd_a_ff.key);
   assign status.dn_move = lt_l || pick_r;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_out_priority    = rsp_entry_ff.key.prio;
   assign rsp_out_created_at  = rsp_entry_ff.key.stamp;
   assign rsp_out_chunk_index = rsp_entry_ff.chunk_no;
   assign rsp_out_peer_slot   = rsp_entry_ff.peer_slot;
   assign rsp_out_retry_count = rsp_entry_ff.retries;
   assign rsp_entry_count     = rsp_count_ff;

endmodule

### rtl/binary_heap_task_queue_core.sv
// Push sifts the new task up one level at a time, at most log2(QUEUE_DEPTH) levels;
// pop and peek answer with the root, and pop then sinks the last entry from the root.
// A new request is taken only while the sequencer is idle. Full, empty and
// unused-opcode requests are answered without touching the heap. The receiver cannot stall.
// Reset clears the entry count and control state; heap contents are not cleared.
// ----------------------------------------------------------------------------
// binary_heap_task_queue_core: bounded min-heap task queue
// Push, pop and peek on a binary min-heap ordered by priority level then
// creation timestamp, with one response strobe per request.
// ----------------------------------------------------------------------------
module binary_heap_task_queue_core import bhtq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_in_priority,
   input  logic [47:0] req_in_created_at,
   input  logic [31:0] req_in_chunk_index,
   input  logic [3:0]  req_in_peer_slot,
   input  logic [2:0]  req_in_retry_count,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_out_priority,
   output logic [47:0] rsp_out_created_at,
   output logic [31:0] rsp_out_chunk_index,
   output logic [3:0]  rsp_out_peer_slot,
   output logic [2:0]  rsp_out_retry_count,
   output logic [8:0]  rsp_entry_count
);

   dp_cmd_type    cmd;
   dp_status_type status;

   bhtq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   bhtq_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_opcode          (req_opcode),
      .req_in_priority     (req_in_priority),
      .req_in_created_at   (req_in_created_at),
      .req_in_chunk_index  (req_in_chunk_index),
      .req_in_peer_slot    (req_in_peer_slot),
      .req_in_retry_count  (req_in_retry_count),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_out_priority    (rsp_out_priority),
      .rsp_out_created_at  (rsp_out_created_at),
      .rsp_out_chunk_index (rsp_out_chunk_index),
      .rsp_out_peer_slot   (rsp_out_peer_slot),
      .rsp_out_retry_count (rsp_out_retry_count),
      .rsp_entry_count     (rsp_entry_count)
   );

   // one response per request, never two strobes back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but sequencer not busy");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == RSP_FULL) |-> rsp_entry_count == ENTRY_W'(QUEUE_DEPTH))
      else $error("full status with queue not at capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == RSP_EMPTY) |-> rsp_entry_count == '0)
      else $error("empty status with entries held");

endmodule

### tb/sv/tb_binary_heap_task_queue_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_heap_task_queue_core: self-checking bench for the heap task queue
// A short directed table (empty corners, key extremes, equal keys, the
// unused opcode) is followed by random fill to full, drain and mixed traffic.
// A software min-heap mirrors the queue and predicts every response that the
// table does not give; tasks with equal keys may come back in any order, so the
// mirror follows the block's choice among them.
// ----------------------------------------------------------------------------
module tb_binary_heap_task_queue_core import bhtq_pkg::*; ();

   localparam int         RUN_ITEMS    = 1850;
   localparam int         IDLE_LIMIT   = 500;
   localparam int         DRAIN_CYCLES = 20;
   localparam int         MAX_REPORTS  = 10;
   localparam int         MAX_GAP      = 18;
   localparam logic [1:0] OP_NOOP      = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      entry_type  ent;
   } task_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] status;
      entry_type  ent;
      logic [8:0] count;
   } queue_reply_type;

   typedef struct packed {
      task_cmd_type    cmd;
      logic            typed;
      queue_reply_type reply;
   } stim_row_type;

   typedef enum logic [1:0] {
      PH_FILL,
      PH_DRAIN,
      PH_MIX
   } load_phase_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_opcode;
   logic [2:0]  req_in_priority;
   logic [47:0] req_in_created_at;
   logic [31:0] req_in_chunk_index;
   logic [3:0]  req_in_peer_slot;
   logic [2:0]  req_in_retry_count;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_out_priority;
   logic [47:0] rsp_out_created_at;
   logic [31:0] rsp_out_chunk_index;
   logic [3:0]  rsp_out_peer_slot;
   logic [2:0]  rsp_out_retry_count;
   logic [8:0]  rsp_entry_count;

   // typed expectation travels with the request it belongs to
   logic            row_typed;
   queue_reply_type row_reply;
   logic            quiet;

   entry_type       heap_mirror [QUEUE_DEPTH];
   int unsigned     mirror_count = 0;
   queue_reply_type reply_queue [$];

   int mismatches   = 0;
   int idle_cycles  = 0;
   int n_push_ok    = 0;
   int n_full       = 0;
   int n_pop_ok     = 0;
   int n_peek_ok    = 0;
   int n_empty      = 0;
   int n_noop       = 0;
   int n_tie_swaps  = 0;
   int peak_count   = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   binary_heap_task_queue_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_in_priority     (req_in_priority),
      .req_in_created_at   (req_in_created_at),
      .req_in_chunk_index  (req_in_chunk_index),
      .req_in_peer_slot    (req_in_peer_slot),
      .req_in_retry_count  (req_in_retry_count),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_out_priority    (rsp_out_priority),
      .rsp_out_created_at  (rsp_out_created_at),
      .rsp_out_chunk_index (rsp_out_chunk_index),
      .rsp_out_peer_slot   (rsp_out_peer_slot),
      .rsp_out_retry_count (rsp_out_retry_count),
      .rsp_entry_count     (rsp_entry_count)
   );

   // ---------------------------------------------------------------- mirror

   function automatic logic key_below(key_type a, key_type b);
      return {a.prio, a.stamp} < {b.prio, b.stamp};
   endfunction

   function automatic void swap_mirror(int unsigned a, int unsigned b);
      entry_type tmp;
      tmp            = heap_mirror[a];
      heap_mirror[a] = heap_mirror[b];
      heap_mirror[b] = tmp;
   endfunction

   task automatic heap_apply(input task_cmd_type c, output queue_reply_type r);
      int unsigned pos;
      int unsigned up;
      int unsigned best;
      int unsigned lc;
      int unsigned rc;
      r    = '0;
      r.op = c.op;
      case (c.op)
         OP_PUSH: begin
            if (mirror_count >= QUEUE_DEPTH) begin
               r.status = RSP_FULL;
            end else begin
               heap_mirror[mirror_count] = c.ent;
               pos = mirror_count;
               while (pos > 0) begin
                  up = (pos - 1) / 2;
                  if (!key_below(heap_mirror[pos].key, heap_mirror[up].key)) break;
                  swap_mirror(pos, up);
                  pos = up;
               end
               mirror_count++;
            end
         end
         OP_POP, OP_PEEK: begin
            if (mirror_count == 0) begin
               r.status = RSP_EMPTY;
            end else begin
               r.ent = heap_mirror[0];
               if (c.op == OP_POP) begin
                  mirror_count--;
                  if (mirror_count > 0) begin
                     heap_mirror[0] = heap_mirror[mirror_count];
                     pos = 0;
                     forever begin
                        best = pos;
                        lc   = 2 * pos + 1;
                        rc   = 2 * pos + 2;
                        if (lc < mirror_count &&
                            key_below(heap_mirror[lc].key, heap_mirror[best].key))
                           best = lc;
                        if (rc < mirror_count &&
                            key_below(heap_mirror[rc].key, heap_mirror[best].key))
                           best = rc;
                        if (best == pos) break;
                        swap_mirror(pos, best);
                        pos = best;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      r.count = mirror_count[8:0];
   endtask

   // Equal keys have no order among themselves: if the block hands out another
   // task with the same key, exchange the two in the mirror and accept it.
   function automatic void settle_tie(ref queue_reply_type want,
                                      input queue_reply_type seen);
      int unsigned j;
      if ((want.op == OP_POP || want.op == OP_PEEK) && want.status == RSP_OK &&
          seen.status == RSP_OK && seen.ent.key == want.ent.key && seen.ent != want.ent) begin
         for (j = 0; j < mirror_count; j++) begin
            if (heap_mirror[j] == seen.ent && !(want.op == OP_PEEK && j == 0)) begin
               heap_mirror[j] = want.ent;
               if (want.op == OP_PEEK) heap_mirror[0] = seen.ent;
               want.ent = seen.ent;
               n_tie_swaps++;
               break;
            end
         end
      end
   endfunction

   task automatic log_mismatch(string what, queue_reply_type want, queue_reply_type seen);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t ERROR %s: op %0d", $realtime, what, want.op);
         $display("   exp st %0d pr %0d ts %h ch %h peer %0d rt %0d cnt %0d",
                  want.status, want.ent.key.prio, want.ent.key.stamp,
                  want.ent.chunk_no, want.ent.peer_slot, want.ent.retries, want.count);
         $display("   got st %0d pr %0d ts %h ch %h peer %0d rt %0d cnt %0d",
                  seen.status, seen.ent.key.prio, seen.ent.key.stamp,
                  seen.ent.chunk_no, seen.ent.peer_slot, seen.ent.retries, seen.count);
      end
   endtask

   // ------------------------------------------------------ check and predict

   always @(posedge clock) begin : check_and_predict
      queue_reply_type seen;
      queue_reply_type want;
      task_cmd_type    cmd;
      logic            took;
      if (!reset) begin
         took = start && !busy;
         // check before predicting, so a request taken on the same edge
         // does not disturb the mirror used for this response
         if (rsp_valid) begin
            seen        = '0;
            seen.status = rsp_status;
            seen.ent    = {rsp_out_priority, rsp_out_created_at, rsp_out_chunk_index,
                           rsp_out_peer_slot, rsp_out_retry_count};
            seen.count  = rsp_entry_count;
            if (reply_queue.size() == 0) begin
               log_mismatch("response with nothing pending", '0, seen);
            end else begin
               want    = reply_queue.pop_front();
               seen.op = want.op;
               settle_tie(want, seen);
               if (seen != want) log_mismatch("response mismatch", want, seen);
               if (seen.count > peak_count) peak_count = seen.count;
               if (want.status == RSP_FULL) n_full++;
               else if (want.status == RSP_EMPTY) n_empty++;
               else if (want.op == OP_PUSH) n_push_ok++;
               else if (want.op == OP_POP) n_pop_ok++;
               else if (want.op == OP_PEEK) n_peek_ok++;
               else n_noop++;
            end
         end
         if (took) begin
            cmd.op  = req_opcode;
            cmd.ent = {req_in_priority, req_in_created_at, req_in_chunk_index,
                       req_in_peer_slot, req_in_retry_count};
            heap_apply(cmd, want);
            if (row_typed) want = row_reply;
            reply_queue.push_back(want);
         end
         if (took || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
      $display("tb_binary_heap_task_queue_core: done, errors");
      $finish;
   end

   // -------------------------------------------------------------- stimulus

   function automatic entry_type make_entry(logic [2:0] prio, logic [47:0] ts,
                                            logic [31:0] chunk, logic [3:0] peer,
                                            logic [2:0] retry);
      return {prio, ts, chunk, peer, retry};
   endfunction

   function automatic stim_row_type mk_row(logic [1:0] op, entry_type ent, logic typed,
                                           logic [1:0] status, entry_type rent,
                                           logic [8:0] count);
      stim_row_type row;
      row.cmd.op       = op;
      row.cmd.ent      = ent;
      row.typed        = typed;
      row.reply.op     = op;
      row.reply.status = status;
      row.reply.ent    = rent;
      row.reply.count  = count;
      return row;
   endfunction

   function automatic entry_type random_entry();
      logic [47:0] ts;
      logic [31:0] chunk;
      int          pick;
      pick = $urandom_range(0, 9);
      // small timestamps make equal keys common
      if (pick < 3) ts = 48'($urandom_range(0, 3));
      else if (pick == 3) ts = '1;
      else if (pick == 4) ts = '0;
      else ts = {16'($urandom), 32'($urandom)};
      pick = $urandom_range(0, 9);
      if (pick == 0) chunk = '0;
      else if (pick == 1) chunk = '1;
      else chunk = $urandom;
      return make_entry(3'($urandom_range(0, 7)), ts, chunk,
                        4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
   endfunction

   task automatic send_request(input task_cmd_type c, input logic typed,
                               input queue_reply_type rep);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_opcode         <= c.op;
      req_in_priority    <= c.ent.key.prio;
      req_in_created_at  <= c.ent.key.stamp;
      req_in_chunk_index <= c.ent.chunk_no;
      req_in_peer_slot   <= c.ent.peer_slot;
      req_in_retry_count <= c.ent.retries;
      row_typed          <= typed;
      row_reply          <= rep;
      start              <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin : stimulus
      stim_row_type   rows [$];
      entry_type      e_max;
      entry_type      e_zero;
      task_cmd_type   cmd;
      load_phase_type phase;
      int             sent;
      int             est_count;
      int             full_hits;
      int             empty_hits;
      int             mix_left;
      int             pick;
      reset              <= 1'b1;
      start              <= 1'b0;
      req_opcode         <= OP_PUSH;
      req_in_priority    <= '0;
      req_in_created_at  <= '0;
      req_in_chunk_index <= '0;
      req_in_peer_slot   <= '0;
      req_in_retry_count <= '0;
      row_typed          <= 1'b0;
      row_reply          <= '0;
      quiet               = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      e_max  = '1;
      e_zero = '0;
      rows.push_back(mk_row(OP_POP,  e_zero, 1'b1, RSP_EMPTY, e_zero, 9'd0));
      rows.push_back(mk_row(OP_PEEK, e_zero, 1'b1, RSP_EMPTY, e_zero, 9'd0));
      rows.push_back(mk_row(OP_NOOP, e_max,  1'b1, RSP_OK,    e_zero, 9'd0));
      rows.push_back(mk_row(OP_PUSH, e_max,  1'b1, RSP_OK,    e_zero, 9'd1));
      rows.push_back(mk_row(OP_PEEK, e_zero, 1'b1, RSP_OK,    e_max,  9'd1));
      rows.push_back(mk_row(OP_PUSH, e_zero, 1'b1, RSP_OK,    e_zero, 9'd2));
      rows.push_back(mk_row(OP_PEEK, e_max,  1'b1, RSP_OK,    e_zero, 9'd2));
      // two tasks with identical keys, then a priority-3 pair in reverse order
      rows.push_back(mk_row(OP_PUSH, make_entry(3'd0, 48'd5, 32'h1234_5678, 4'd5, 3'd2),
                            1'b0, RSP_OK, e_zero, 9'd0));
      rows.push_back(mk_row(OP_PUSH, make_entry(3'd0, 48'd5, 32'h8765_4321, 4'd10, 3'd5),
                            1'b0, RSP_OK, e_zero, 9'd0));
      rows.push_back(mk_row(OP_PUSH, make_entry(3'd3, 48'd1, 32'hA5A5_A5A5, 4'd3, 3'd1),
                            1'b0, RSP_OK, e_zero, 9'd0));
      rows.push_back(mk_row(OP_PUSH, make_entry(3'd3, 48'd0, 32'h5A5A_5A5A, 4'd12, 3'd6),
                            1'b0, RSP_OK, e_zero, 9'd0));
      rows.push_back(mk_row(OP_NOOP, e_zero, 1'b0, RSP_OK, e_zero, 9'd0));
      repeat (5) rows.push_back(mk_row(OP_POP, e_zero, 1'b0, RSP_OK, e_zero, 9'd0));
      rows.push_back(mk_row(OP_POP,  e_zero, 1'b1, RSP_OK,    e_max,  9'd0));
      rows.push_back(mk_row(OP_POP,  e_zero, 1'b1, RSP_EMPTY, e_zero, 9'd0));
      rows.push_back(mk_row(OP_PUSH, make_entry(3'd0, '1, '0, 4'd0, 3'd0),
                            1'b0, RSP_OK, e_zero, 9'd0));
      rows.push_back(mk_row(OP_PUSH, make_entry(3'd7, '0, '1, 4'd15, 3'd7),
                            1'b0, RSP_OK, e_zero, 9'd0));
      rows.push_back(mk_row(OP_POP,  e_zero, 1'b0, RSP_OK, e_zero, 9'd0));
      rows.push_back(mk_row(OP_POP,  e_zero, 1'b0, RSP_OK, e_zero, 9'd0));
      rows.push_back(mk_row(OP_PEEK, e_zero, 1'b1, RSP_EMPTY, e_zero, 9'd0));

      sent = 0;
      foreach (rows[i]) begin
         send_request(rows[i].cmd, rows[i].typed, rows[i].reply);
         if (rows[i].cmd.op != OP_NOOP) sent++;
      end

      // random traffic: fill to the top, drain to the bottom, then mix
      phase      = PH_FILL;
      est_count  = 0;
      full_hits  = 0;
      empty_hits = 0;
      mix_left   = 0;
      while (sent < RUN_ITEMS) begin
         if (sent % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         case (phase)
            PH_FILL:  cmd.op = pick < 90 ? OP_PUSH : pick < 95 ? OP_POP :
                               pick < 99 ? OP_PEEK : OP_NOOP;
            PH_DRAIN: cmd.op = pick < 88 ? OP_POP : pick < 94 ? OP_PUSH :
                               pick < 99 ? OP_PEEK : OP_NOOP;
            default:  cmd.op = pick < 45 ? OP_PUSH : pick < 85 ? OP_POP :
                               pick < 98 ? OP_PEEK : OP_NOOP;
         endcase
         cmd.ent = random_entry();
         send_request(cmd, 1'b0, '0);
         if (cmd.op != OP_NOOP) sent++;

         if (cmd.op == OP_PUSH) begin
            if (est_count == QUEUE_DEPTH) full_hits++;
            else est_count++;
         end else if (cmd.op == OP_POP || cmd.op == OP_PEEK) begin
            if (est_count == 0) empty_hits++;
            else if (cmd.op == OP_POP) est_count--;
         end

         case (phase)
            PH_FILL: begin
               if (full_hits >= 6) begin
                  phase      = PH_DRAIN;
                  empty_hits = 0;
               end
            end
            PH_DRAIN: begin
               if (empty_hits >= 6) begin
                  phase    = PH_MIX;
                  mix_left = 300;
               end
            end
            default: begin
               mix_left--;
               if (mix_left <= 0) begin
                  phase     = PH_FILL;
                  full_hits = 0;
               end
            end
         endcase
      end
      start <= 1'b0;

      @(posedge clock);
      while (reply_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d pushes taken, %0d refused full, %0d pops, %0d peeks, %0d empty replies",
               n_push_ok, n_full, n_pop_ok, n_peek_ok, n_empty);
      $display("run: %0d no-ops, peak occupancy %0d of %0d, %0d equal-key reorders, %0d mismatches",
               n_noop, peak_count, QUEUE_DEPTH, n_tie_swaps, mismatches);
      if (mismatches == 0) begin
         $display("tb_binary_heap_task_queue_core: done, clean");
      end else begin
         $display("tb_binary_heap_task_queue_core: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/bhtq_pkg.sv
rtl/bhtq_ctrl.sv
rtl/bhtq_datapath.sv
rtl/binary_heap_task_queue_core.sv
tb/sv/tb_binary_heap_task_queue_core.sv
